>>> hw/rtl/lpht_pkg.sv
// ----------------------------------------------------------------------------
// lpht_pkg: shared definitions for the linear probe hash table
// Request codes, slot marks, register indexes, state types and widths.
// ----------------------------------------------------------------------------
package lpht_pkg;

  localparam int TABLE_SLOTS_DEF = 1024;
  localparam int KEY_BYTES_DEF   = 8;

  localparam int REQ_W      = 3;
  localparam int KEY_W      = 64;
  localparam int SLOT_W     = 10;
  localparam int TOTAL_W    = 10;
  localparam int TSIZE_W    = 11;
  localparam int MAXE_W     = 10;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;
  localparam int HPOLY_W    = 30;

  localparam logic [TSIZE_W-1:0] TSIZE_RST = 11'd1024;
  localparam logic [MAXE_W-1:0]  MAXE_RST  = 10'd1023;

  typedef enum logic [REQ_W-1:0] {
    REQ_FIND       = 3'd0,
    REQ_ENTER      = 3'd1,
    REQ_REMOVE     = 3'd2,
    REQ_CLEAN      = 3'd3,
    REQ_SCAN_RESET = 3'd4,
    REQ_SCAN_NEXT  = 3'd5
  } req_t;

  typedef enum logic [1:0] {
    MARK_EMPTY   = 2'd0,
    MARK_USED    = 2'd1,
    MARK_REMOVED = 2'd2
  } mark_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TABLE_SIZE  = 4'd0,
    REG_MAX_ENTRIES = 4'd1
  } cfg_reg_t;

  typedef struct packed {
    logic rd_en;
    logic mark_we;
    logic key_we;
  } store_ctl_t;

  typedef enum logic [1:0] {
    H_IDLE,
    H_POLY,
    H_MOD
  } hash_state_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_PROBE_RD,
    ST_PROBE_CHK,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_RESP
  } top_state_t;

endpackage

>>> hw/rtl/lpht_if.sv
// ----------------------------------------------------------------------------
// lpht channel interfaces
// Request, response and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface lpht_req_if;
  import lpht_pkg::*;
  logic             valid;
  logic             ready;
  logic [REQ_W-1:0] req_type;
  logic [KEY_W-1:0] key;
  modport source (output valid, req_type, key, input ready);
  modport sink   (input valid, req_type, key, output ready);
endinterface

interface lpht_rsp_if;
  import lpht_pkg::*;
  logic               valid;
  logic               ready;
  logic               found;
  logic               slot_valid;
  logic [SLOT_W-1:0]  slot;
  logic [TOTAL_W-1:0] entry_total;
  modport source (output valid, found, slot_valid, slot, entry_total, input ready);
  modport sink   (input valid, found, slot_valid, slot, entry_total, output ready);
endinterface

interface lpht_cfg_if;
  import lpht_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  reg_index;
  logic [CFG_DATA_W-1:0] wdata;
  modport source (output valid, reg_index, wdata, input ready);
  modport sink   (input valid, reg_index, wdata, output ready);
endinterface

>>> hw/rtl/lpht_hash.sv
// ----------------------------------------------------------------------------
// lpht_hash: byte-serial key hash and modulo reduction
// One multiplier evaluates the byte polynomial by Horner steps, then a
// shift-subtract loop reduces the 64-bit sum modulo the live table size.
// ----------------------------------------------------------------------------
module lpht_hash #(
  parameter int TABLE_SLOTS = lpht_pkg::TABLE_SLOTS_DEF,
  parameter int KEY_BYTES   = lpht_pkg::KEY_BYTES_DEF,
  localparam int IDX_W = (TABLE_SLOTS > 2) ? $clog2(TABLE_SLOTS) : 1,
  localparam int CNT_W = IDX_W + 1
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [lpht_pkg::KEY_W-1:0]   key,
  input  logic [CNT_W-1:0]             size_n,
  output logic                         done,
  output logic [IDX_W-1:0]             first
);
  import lpht_pkg::*;

  localparam int BC_W = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;

  hash_state_t               hstate_r, hstate_nxt;
  logic [BC_W-1:0]           byte_r, byte_nxt;
  logic [1:0]                step_r, step_nxt;
  logic signed [HPOLY_W-1:0] h_r, h_nxt;
  logic [KEY_W-1:0]          sum_r, sum_nxt;
  logic [KEY_W-1:0]          key_r, key_nxt;
  logic [5:0]                bit_r, bit_nxt;
  logic [CNT_W-1:0]          rem_r, rem_nxt;
  logic [CNT_W-1:0]          n_r, n_nxt;
  logic                      done_r, done_nxt;

  logic signed [7:0]           xb;
  logic signed [HPOLY_W+7:0]   prod;
  logic signed [HPOLY_W-1:0]   h_step;
  logic [CNT_W:0]              rem_sh;

  assign xb     = key_r[8*byte_r +: 8];
  assign prod   = h_r * xb;
  assign h_step = prod[HPOLY_W-1:0] + HPOLY_W'(1);
  assign rem_sh = {rem_r, sum_r[KEY_W-1]};

  always_comb begin
    hstate_nxt = hstate_r;
    unique case (hstate_r)
      H_IDLE: if (start) hstate_nxt = H_POLY;
      H_POLY: if (step_r == 2'd3 && byte_r == BC_W'(KEY_BYTES - 1)) hstate_nxt = H_MOD;
      H_MOD:  if (bit_r == 6'd63) hstate_nxt = H_IDLE;
      default: hstate_nxt = H_IDLE;
    endcase
  end

  always_comb begin
    byte_nxt = byte_r;
    step_nxt = step_r;
    h_nxt    = h_r;
    sum_nxt  = sum_r;
    key_nxt  = key_r;
    bit_nxt  = bit_r;
    rem_nxt  = rem_r;
    n_nxt    = n_r;
    done_nxt = 1'b0;
    unique case (hstate_r)
      H_IDLE: begin
        if (start) begin
          key_nxt  = key;
          n_nxt    = size_n;
          sum_nxt  = '0;
          byte_nxt = '0;
          step_nxt = '0;
          h_nxt    = HPOLY_W'(1);
        end
      end
      H_POLY: begin
        // Horner form: ((((x+1)x+1)x+1)x+1) after four steps from one.
        step_nxt = step_r + 2'd1;
        h_nxt    = h_step;
        if (step_r == 2'd3) begin
          sum_nxt  = sum_r + {{(KEY_W-HPOLY_W){h_step[HPOLY_W-1]}}, h_step};
          h_nxt    = HPOLY_W'(1);
          byte_nxt = byte_r + BC_W'(1);
          bit_nxt  = '0;
          rem_nxt  = '0;
        end
      end
      H_MOD: begin
        if (rem_sh >= {1'b0, n_r}) rem_nxt = CNT_W'(rem_sh - {1'b0, n_r});
        else                       rem_nxt = CNT_W'(rem_sh);
        sum_nxt = {sum_r[KEY_W-2:0], 1'b0};
        bit_nxt = bit_r + 6'd1;
        if (bit_r == 6'd63) done_nxt = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hstate_r <= H_IDLE;
      done_r   <= 1'b0;
    end else begin
      hstate_r <= hstate_nxt;
      done_r   <= done_nxt;
    end
    byte_r <= byte_nxt;
    step_r <= step_nxt;
    h_r    <= h_nxt;
    sum_r  <= sum_nxt;
    key_r  <= key_nxt;
    bit_r  <= bit_nxt;
    rem_r  <= rem_nxt;
    n_r    <= n_nxt;
  end

  assign done  = done_r;
  assign first = rem_r[IDX_W-1:0];

endmodule

>>> hw/rtl/lpht_store.sv
// ----------------------------------------------------------------------------
// lpht_store: slot mark and key memories
// One write address and one read address per cycle, read data registered.
// ----------------------------------------------------------------------------
module lpht_store #(
  parameter int TABLE_SLOTS = lpht_pkg::TABLE_SLOTS_DEF,
  localparam int IDX_W = (TABLE_SLOTS > 2) ? $clog2(TABLE_SLOTS) : 1
) (
  input  logic                        clk,
  input  lpht_pkg::store_ctl_t        ctl,
  input  logic [IDX_W-1:0]            raddr,
  input  logic [IDX_W-1:0]            waddr,
  input  lpht_pkg::mark_t             mark_wdata,
  input  logic [lpht_pkg::KEY_W-1:0]  key_wdata,
  output lpht_pkg::mark_t             rd_mark,
  output logic [lpht_pkg::KEY_W-1:0]  rd_key
);
  import lpht_pkg::*;

  mark_t            mark_mem [TABLE_SLOTS];
  logic [KEY_W-1:0] key_mem  [TABLE_SLOTS];

  always_ff @(posedge clk) begin
    if (ctl.mark_we) mark_mem[waddr] <= mark_wdata;
    if (ctl.rd_en)   rd_mark <= mark_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (ctl.key_we) key_mem[waddr] <= key_wdata;
    if (ctl.rd_en)  rd_key <= key_mem[raddr];
  end

endmodule

>>> hw/rtl/linear_probe_hash_table.sv
// ----------------------------------------------------------------------------
// linear_probe_hash_table: open-addressing key table with linear probing
// Find, enter and remove keys; clean the table; walk the used slots.
// ----------------------------------------------------------------------------
//   channel   direction  carries
//   in_ch     sink       req_type, key
//   out_ch    source     found, slot_valid, slot, entry_total
//   cfg_ch    sink       reg_index, wdata (table_size, max_entries)
//
// Find, enter and remove hash the key (Horner steps per key byte, then modulo
// reduction), hand the first slot over and probe slots in turn, each with a
// read state and a check state on the memory read port.
// Scan next steps over slots with a read state and a check state per slot.
// After reset, and on a clean request, a sweep over every slot empties
// the slot marks. One request is in work at a time; in_ch is not ready until
// the response transfer on out_ch completes.
module linear_probe_hash_table #(
  parameter int TABLE_SLOTS = lpht_pkg::TABLE_SLOTS_DEF,
  parameter int KEY_BYTES   = lpht_pkg::KEY_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  lpht_req_if.sink    in_ch,
  lpht_rsp_if.source  out_ch,
  lpht_cfg_if.sink    cfg_ch
);
  import lpht_pkg::*;

  localparam int IDX_W = (TABLE_SLOTS > 2) ? $clog2(TABLE_SLOTS) : 1;
  localparam int CNT_W = IDX_W + 1;
  localparam int CW    = (CNT_W > TSIZE_W) ? CNT_W : TSIZE_W;
  localparam logic [KEY_W-1:0] KEY_MASK = {KEY_W{1'b1}} >> (KEY_W - 8 * KEY_BYTES);

  top_state_t         state_r, state_nxt;
  logic [TSIZE_W-1:0] tsize_r;
  logic [MAXE_W-1:0]  maxe_r;
  req_t               req_r, req_nxt;
  logic [KEY_W-1:0]   key_r, key_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic [IDX_W-1:0]   first_r, first_nxt;
  logic [IDX_W-1:0]   rem_r, rem_nxt;
  logic               have_rem_r, have_rem_nxt;
  logic [TOTAL_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0]   scan_r, scan_nxt;
  logic [IDX_W-1:0]   scan_p_r, scan_p_nxt;
  logic [IDX_W-1:0]   clr_ptr_r, clr_ptr_nxt;
  logic               clr_resp_r, clr_resp_nxt;
  logic               found_r, found_nxt;
  logic               valid_r, valid_nxt;
  logic [SLOT_W-1:0]  slot_r, slot_nxt;

  logic [CW-1:0]      ts_ext, n_ext, nm1_ext;
  logic [CNT_W-1:0]   size_n;
  logic [MAXE_W-1:0]  cap;

  logic               in_xfer, out_xfer, hash_start, hash_done;
  logic [IDX_W-1:0]   hash_first;
  req_t               in_req;

  store_ctl_t         st_ctl;
  logic [IDX_W-1:0]   st_raddr, st_waddr;
  mark_t              st_mark_wdata, rd_mark;
  logic [KEY_W-1:0]   rd_key;

  logic               is_empty, is_hit, is_enter, room, rem_take, have_eff, wrapped;
  logic [IDX_W-1:0]   rem_eff, ins_slot, idx_next;
  logic [CNT_W-1:0]   idx_inc;

  // Configuration registers; the port never stalls.
  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tsize_r <= TSIZE_RST;
      maxe_r  <= MAXE_RST;
    end else if (cfg_ch.valid) begin
      if (cfg_ch.reg_index == REG_TABLE_SIZE)  tsize_r <= cfg_ch.wdata[TSIZE_W-1:0];
      if (cfg_ch.reg_index == REG_MAX_ENTRIES) maxe_r  <= cfg_ch.wdata[MAXE_W-1:0];
    end
  end

  // Live size clamped between 2 and the physical table, capacity below the size.
  always_comb begin
    ts_ext = CW'(tsize_r);
    if (ts_ext < CW'(2))                n_ext = CW'(2);
    else if (ts_ext > CW'(TABLE_SLOTS)) n_ext = CW'(TABLE_SLOTS);
    else                                n_ext = ts_ext;
    nm1_ext = n_ext - CW'(1);
    size_n  = CNT_W'(n_ext);
    cap     = (CW'(maxe_r) > nm1_ext) ? MAXE_W'(nm1_ext) : maxe_r;
  end

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign in_req      = req_t'(in_ch.req_type);
  assign out_xfer    = out_ch.valid && out_ch.ready;
  assign hash_start  = in_xfer && (in_req == REQ_FIND || in_req == REQ_ENTER ||
                                   in_req == REQ_REMOVE);

  lpht_hash #(
    .TABLE_SLOTS (TABLE_SLOTS),
    .KEY_BYTES   (KEY_BYTES)
  ) u_hash (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (hash_start),
    .key    (in_ch.key & KEY_MASK),
    .size_n (size_n),
    .done   (hash_done),
    .first  (hash_first)
  );

  lpht_store #(
    .TABLE_SLOTS (TABLE_SLOTS)
  ) u_store (
    .clk        (clk),
    .ctl        (st_ctl),
    .raddr      (st_raddr),
    .waddr      (st_waddr),
    .mark_wdata (st_mark_wdata),
    .key_wdata  (key_r),
    .rd_mark    (rd_mark),
    .rd_key     (rd_key)
  );

  // Probe decisions on the slot read in the previous cycle.
  always_comb begin
    is_empty = (rd_mark == MARK_EMPTY);
    is_hit   = (rd_mark == MARK_USED) && (rd_key == key_r);
    is_enter = (req_r == REQ_ENTER);
    room     = (count_r < cap);
    rem_take = is_enter && !have_rem_r && (rd_mark == MARK_REMOVED);
    have_eff = have_rem_r || rem_take;
    rem_eff  = have_rem_r ? rem_r : idx_r;
    ins_slot = have_rem_r ? rem_r : idx_r;
    idx_inc  = CNT_W'(idx_r) + CNT_W'(1);
    idx_next = (idx_inc >= size_n) ? '0 : idx_inc[IDX_W-1:0];
    wrapped  = (idx_next == first_r);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (clr_ptr_r == IDX_W'(TABLE_SLOTS - 1)) state_nxt = clr_resp_r ? ST_RESP : ST_IDLE;
      end
      ST_IDLE: begin
        if (in_xfer) begin
          unique case (in_req)
            REQ_FIND, REQ_ENTER, REQ_REMOVE: state_nxt = ST_HASH;
            REQ_CLEAN:                       state_nxt = ST_CLEAR;
            REQ_SCAN_NEXT:                   state_nxt = ST_SCAN_RD;
            default:                         state_nxt = ST_RESP;
          endcase
        end
      end
      ST_HASH:      if (hash_done) state_nxt = ST_PROBE_RD;
      ST_PROBE_RD:  state_nxt = ST_PROBE_CHK;
      ST_PROBE_CHK: state_nxt = (is_empty || is_hit || wrapped) ? ST_RESP : ST_PROBE_RD;
      ST_SCAN_RD:   state_nxt = (scan_r >= size_n) ? ST_RESP : ST_SCAN_CHK;
      ST_SCAN_CHK:  state_nxt = (rd_mark == MARK_USED) ? ST_RESP : ST_SCAN_RD;
      ST_RESP:      if (out_xfer) state_nxt = ST_IDLE;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    req_nxt       = req_r;
    key_nxt       = key_r;
    idx_nxt       = idx_r;
    first_nxt     = first_r;
    rem_nxt       = rem_r;
    have_rem_nxt  = have_rem_r;
    count_nxt     = count_r;
    scan_nxt      = scan_r;
    scan_p_nxt    = scan_p_r;
    clr_ptr_nxt   = clr_ptr_r;
    clr_resp_nxt  = clr_resp_r;
    found_nxt     = found_r;
    valid_nxt     = valid_r;
    slot_nxt      = slot_r;
    st_ctl        = '0;
    st_raddr      = idx_r;
    st_waddr      = idx_r;
    st_mark_wdata = MARK_USED;
    unique case (state_r)
      ST_CLEAR: begin
        st_ctl.mark_we = 1'b1;
        st_waddr       = clr_ptr_r;
        st_mark_wdata  = MARK_EMPTY;
        clr_ptr_nxt    = clr_ptr_r + IDX_W'(1);
      end
      ST_IDLE: begin
        if (in_xfer) begin
          req_nxt      = in_req;
          key_nxt      = in_ch.key & KEY_MASK;
          found_nxt    = 1'b0;
          valid_nxt    = 1'b0;
          slot_nxt     = '0;
          have_rem_nxt = 1'b0;
          if (in_req == REQ_CLEAN) begin
            count_nxt    = '0;
            scan_nxt     = '0;
            clr_ptr_nxt  = '0;
            clr_resp_nxt = 1'b1;
          end
          if (in_req == REQ_SCAN_RESET) scan_nxt = '0;
        end
      end
      ST_HASH: begin
        if (hash_done) begin
          idx_nxt   = hash_first;
          first_nxt = hash_first;
        end
      end
      ST_PROBE_RD: begin
        st_ctl.rd_en = 1'b1;
        st_raddr     = idx_r;
      end
      ST_PROBE_CHK: begin
        if (is_empty) begin
          if (is_enter && room) begin
            st_ctl.mark_we = 1'b1;
            st_ctl.key_we  = 1'b1;
            st_waddr       = ins_slot;
            valid_nxt      = 1'b1;
            slot_nxt       = SLOT_W'(ins_slot);
            count_nxt      = count_r + TOTAL_W'(1);
          end
        end else if (is_hit) begin
          found_nxt = 1'b1;
          valid_nxt = 1'b1;
          slot_nxt  = SLOT_W'(idx_r);
          if (req_r == REQ_REMOVE) begin
            st_ctl.mark_we = 1'b1;
            st_waddr       = idx_r;
            st_mark_wdata  = MARK_REMOVED;
            if (count_r != '0) count_nxt = count_r - TOTAL_W'(1);
          end
        end else begin
          have_rem_nxt = have_eff;
          if (rem_take) rem_nxt = idx_r;
          idx_nxt = idx_next;
          // Back at the start: an enter may still land in a removed slot.
          if (wrapped && is_enter && have_eff && room) begin
            st_ctl.mark_we = 1'b1;
            st_ctl.key_we  = 1'b1;
            st_waddr       = rem_eff;
            valid_nxt      = 1'b1;
            slot_nxt       = SLOT_W'(rem_eff);
            count_nxt      = count_r + TOTAL_W'(1);
          end
        end
      end
      ST_SCAN_RD: begin
        if (scan_r < size_n) begin
          st_ctl.rd_en = 1'b1;
          st_raddr     = scan_r[IDX_W-1:0];
          scan_p_nxt   = scan_r[IDX_W-1:0];
          scan_nxt     = scan_r + CNT_W'(1);
        end
      end
      ST_SCAN_CHK: begin
        if (rd_mark == MARK_USED) begin
          valid_nxt = 1'b1;
          slot_nxt  = SLOT_W'(scan_p_r);
        end
      end
      ST_RESP: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      clr_ptr_r  <= '0;
      clr_resp_r <= 1'b0;
      count_r    <= '0;
      scan_r     <= '0;
      have_rem_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      clr_ptr_r  <= clr_ptr_nxt;
      clr_resp_r <= clr_resp_nxt;
      count_r    <= count_nxt;
      scan_r     <= scan_nxt;
      have_rem_r <= have_rem_nxt;
    end
    req_r    <= req_nxt;
    key_r    <= key_nxt;
    idx_r    <= idx_nxt;
    first_r  <= first_nxt;
    rem_r    <= rem_nxt;
    scan_p_r <= scan_p_nxt;
    found_r  <= found_nxt;
    valid_r  <= valid_nxt;
    slot_r   <= slot_nxt;
  end

  assign out_ch.valid       = (state_r == ST_RESP);
  assign out_ch.found       = found_r;
  assign out_ch.slot_valid  = valid_r;
  assign out_ch.slot        = slot_r;
  assign out_ch.entry_total = count_r;

endmodule
